// ----- hdl/cbb_pkg.sv -----
package cbb_pkg;

	localparam int MAX_KNOTS = 64;
	localparam int KNOT_AW   = 6;
	localparam int BANK_AW   = 3;
	localparam int NBANKS    = 1 << BANK_AW;
	localparam int ROW_AW    = KNOT_AW - BANK_AW;
	localparam int KROWS     = MAX_KNOTS / NBANKS;

	localparam int KW = 32;  // knot and point width, Q16.16
	localparam int BW = 31;  // basis width, Q1.30
	localparam int MW = 32;  // magnitude of a knot difference
	localparam int PW = MW + BW - 1;  // product magnitude bits, below 2^62
	localparam int DIV_STEPS = PW;
	localparam int LATENCY = 2 + 3 * (DIV_STEPS + 3) + 1;

	localparam logic [BW-1:0] UNIT_Q30 = BW'(1) << 30;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	typedef struct packed {
		logic                     last;
		logic [3:0][3:0]          gate;  // gate[degree][lane]
		logic signed [KW-1:0]     x;
		logic [7:0][KW-1:0]       knot;  // knot[m] is t[span-3+m]
	} ctx_t;

	typedef struct packed {
		ctx_t            ctx;
		logic [3:0][1:0] neg;
		logic [3:0][1:0] dz;
	} side_t;

	function automatic logic signed [KW:0] sx33(input logic [KW-1:0] v);
		return $signed({v[KW-1], v});
	endfunction

	function automatic logic [MW-1:0] mag33(input logic signed [KW:0] v);
		logic [KW:0] t;
		t = v[KW] ? (KW+1)'(-v) : v;
		return t[MW-1:0];
	endfunction

	function automatic logic [BW-1:0] clamp_unit(input logic signed [63:0] v);
		logic [BW-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({33'b0, UNIT_Q30})) begin
			r = UNIT_Q30;
		end else begin
			r = v[BW-1:0];
		end
		return r;
	endfunction

endpackage

// ----- hdl/cbb_div.sv -----
module cbb_div import cbb_pkg::*; (
	input  logic          clk,
	input  logic [PW-1:0] dividend,
	input  logic [MW-1:0] divisor,
	output logic [PW-1:0] quotient
);

	logic [MW-1:0] rem_s  [1:DIV_STEPS-1];
	logic [PW-1:0] work_s [1:DIV_STEPS];
	logic [MW-1:0] dvs_s  [1:DIV_STEPS-1];

	// one restoring step per stage, quotient bits shift in as dividend bits leave
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic [MW-1:0] rin;
		logic [PW-1:0] win;
		logic [MW-1:0] din;
		logic [MW:0]   trial;
		logic          ge;

		if (j == 0) begin : g_first
			assign rin = '0;
			assign win = dividend;
			assign din = divisor;
		end else begin : g_next
			assign rin = rem_s[j];
			assign win = work_s[j];
			assign din = dvs_s[j];
		end

		assign trial = {rin, win[PW-1]};
		assign ge    = trial >= {1'b0, din};

		always_ff @(posedge clk) begin
			work_s[j+1] <= {win[PW-2:0], ge};
		end

		// the last step only leaves its quotient bit
		if (j < DIV_STEPS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[j+1] <= ge ? MW'(trial - {1'b0, din}) : trial[MW-1:0];
				dvs_s[j+1] <= din;
			end
		end
	end

	assign quotient = work_s[DIV_STEPS];

endmodule

// ----- hdl/cubic_bspline_basis_eval.sv -----
// cubic B-spline basis evaluator, Cox-de Boor recursion for degrees 0 to 3
// input: an item is taken at each rising edge where start is high and busy
// is low; busy stays low, so an item may enter on every cycle. mode 0 writes
// knot_value to knot_addr, mode 1 evaluates the four basis values at point_x
// in span span_index.
// output: each evaluate item gives one result, shown on the basis ports for
// exactly one cycle with done high. load items give no result. the receiver
// cannot stall; the pipeline never holds. throughput is one item per cycle;
// most of the pipeline is the three degree stages, each a multiply and a
// 62-step one-bit-per-stage divider. a load is visible to an evaluate item
// taken on the very next cycle.
// config: cfg_data sets the knot count, written when cfg_valid is high
// (cfg_ready stays high); write it only while no result is pending.
// reset: clears the pipeline valid bits and sets the knot count to 64; the
// knot store holds garbage until loaded.
module cubic_bspline_basis_eval import cbb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 mode,
	input  logic [KNOT_AW-1:0]   knot_addr,
	input  logic signed [KW-1:0] knot_value,
	input  logic [KNOT_AW-1:0]   span_index,
	input  logic signed [KW-1:0] point_x,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [6:0]           cfg_data,
	output logic                 done,
	output logic [BW-1:0]        basis_i,
	output logic [BW-1:0]        basis_i_minus1,
	output logic [BW-1:0]        basis_i_minus2,
	output logic [BW-1:0]        basis_i_minus3
);

	logic [6:0] knot_count_q;
	logic [6:0] nsat;
	logic [6:0] n_m1;
	logic       load;
	logic       eval;
	logic [KNOT_AW-1:0] base;

	logic [KW-1:0]      knot_rd_s1 [NBANKS];
	logic [KW-1:0]      mem_all [MAX_KNOTS];
	logic [KW-1:0]      lastk_s1;
	logic               vld_s1;
	logic [KNOT_AW-1:0] span_s1;
	logic signed [KW-1:0] x_s1;
	logic [6:0]         nsat_s1;

	ctx_t               ctx0;
	logic [3:0][BW-1:0] cur0;
	logic [KNOT_AW-1:0] base1;

	ctx_t               ctx_c [0:3];
	logic [3:0][BW-1:0] cur_c [0:3];
	logic               vld_c [0:3];

	logic               done_q;
	logic [3:0][BW-1:0] basis_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign load      = start && (mode == MODE_LOAD);
	assign eval      = start && (mode == MODE_EVAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knot_count_q <= 7'(MAX_KNOTS);
		end else if (cfg_valid && cfg_ready) begin
			knot_count_q <= cfg_data;
		end
	end

	always_comb begin
		if (knot_count_q < 7'd2) begin
			nsat = 7'd2;
		end else if (knot_count_q > 7'(MAX_KNOTS)) begin
			nsat = 7'(MAX_KNOTS);
		end else begin
			nsat = knot_count_q;
		end
		n_m1 = nsat - 7'd1;
	end

	// eight consecutive knots t[span-3..span+4] land in eight distinct banks
	assign base = span_index - KNOT_AW'(3);

	for (genvar b = 0; b < NBANKS; b++) begin : g_bank
		logic [KW-1:0]      mem [KROWS];
		logic [BANK_AW-1:0] off;
		logic [KNOT_AW-1:0] addr;

		assign off  = BANK_AW'(b) - base[BANK_AW-1:0];
		assign addr = base + {{ROW_AW{1'b0}}, off};

		always_ff @(posedge clk) begin
			if (load && knot_addr[BANK_AW-1:0] == BANK_AW'(b)) begin
				mem[knot_addr[KNOT_AW-1:BANK_AW]] <= knot_value;
			end
			knot_rd_s1[b] <= mem[addr[KNOT_AW-1:BANK_AW]];
		end
	end

	// full copy serves the last-knot lookup
	always_ff @(posedge clk) begin
		if (load) begin
			mem_all[knot_addr] <= knot_value;
		end
		lastk_s1 <= mem_all[n_m1[KNOT_AW-1:0]];
		span_s1  <= span_index;
		x_s1     <= point_x;
		nsat_s1  <= nsat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= eval;
		end
	end

	// degree 0: reorder banks, lane gates, span membership
	always_comb begin
		base1 = span_s1 - KNOT_AW'(3);
		ctx0.x    = x_s1;
		ctx0.last = (x_s1 == $signed(lastk_s1));
		for (int m = 0; m < 8; m++) begin
			ctx0.knot[m] = knot_rd_s1[BANK_AW'(base1[BANK_AW-1:0] + BANK_AW'(m))];
		end
		for (int p = 0; p < 4; p++) begin
			for (int k = 0; k < 4; k++) begin
				ctx0.gate[p][k] = (span_s1 >= KNOT_AW'(k)) &&
					({2'b0, span_s1} + 8'(p + 1) < {1'b0, nsat_s1} + 8'(k));
			end
		end
		for (int k = 0; k < 4; k++) begin
			cur0[k] = (ctx0.gate[0][k] && $signed(ctx0.knot[3-k]) <= x_s1 &&
				x_s1 < $signed(ctx0.knot[4-k])) ? UNIT_Q30 : '0;
		end
	end

	always_ff @(posedge clk) begin
		ctx_c[0] <= ctx0;
		cur_c[0] <= cur0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c[0] <= 1'b0;
		end else begin
			vld_c[0] <= vld_s1;
		end
	end

	for (genvar p = 1; p <= 3; p++) begin : g_deg
		logic signed [KW:0] nd [4][2];
		logic signed [KW:0] dd [4][2];

		logic [3:0][1:0][MW-1:0] nmag_s1;
		logic [3:0][1:0][MW-1:0] dmag_s1;
		logic [3:0][1:0][BW-1:0] bmul_s1;
		side_t                   side_s1;
		logic                    vld_s1d;

		logic [3:0][1:0][PW-1:0] prod_s2;
		logic [3:0][1:0][MW-1:0] dmag_s2;
		side_t                   side_s2;
		logic                    vld_s2;

		wire  [3:0][1:0][PW-1:0] quo;
		side_t                   side_dly_q [1:DIV_STEPS];
		logic [DIV_STEPS-1:0]    vld_dly_q;

		logic signed [63:0]      term [4][2];
		logic [3:0][BW-1:0]      res;
		side_t                   sd;

		// left term (x - t[idx]) / (t[idx+p] - t[idx]),
		// right term (t[idx+p+1] - x) / (t[idx+p+1] - t[idx+1])
		always_comb begin
			for (int k = 0; k < 4; k++) begin
				nd[k][0] = sx33(ctx_c[p-1].x) - sx33(ctx_c[p-1].knot[3-k]);
				dd[k][0] = sx33(ctx_c[p-1].knot[3-k+p]) - sx33(ctx_c[p-1].knot[3-k]);
				nd[k][1] = sx33(ctx_c[p-1].knot[4-k+p]) - sx33(ctx_c[p-1].x);
				dd[k][1] = sx33(ctx_c[p-1].knot[4-k+p]) - sx33(ctx_c[p-1].knot[4-k]);
			end
		end

		always_ff @(posedge clk) begin
			side_s1.ctx <= ctx_c[p-1];
			for (int k = 0; k < 4; k++) begin
				for (int t = 0; t < 2; t++) begin
					nmag_s1[k][t]     <= mag33(nd[k][t]);
					dmag_s1[k][t]     <= mag33(dd[k][t]);
					side_s1.neg[k][t] <= nd[k][t][KW] ^ dd[k][t][KW];
					side_s1.dz[k][t]  <= (dd[k][t] == '0);
				end
				bmul_s1[k][0] <= cur_c[p-1][k];
				bmul_s1[k][1] <= (k > 0) ? cur_c[p-1][(k + 3) % 4] : '0;
			end
		end

		always_ff @(posedge clk) begin
			side_s2 <= side_s1;
			dmag_s2 <= dmag_s1;
			for (int k = 0; k < 4; k++) begin
				for (int t = 0; t < 2; t++) begin
					prod_s2[k][t] <= {{(PW-MW){1'b0}}, nmag_s1[k][t]} *
						{{(PW-BW){1'b0}}, bmul_s1[k][t]};
				end
			end
		end

		for (genvar k = 0; k < 4; k++) begin : g_lane
			for (genvar t = 0; t < 2; t++) begin : g_term
				cbb_div u_div (
					.clk      (clk),
					.dividend (prod_s2[k][t]),
					.divisor  (dmag_s2[k][t]),
					.quotient (quo[k][t])
				);
			end
		end

		always_ff @(posedge clk) begin
			side_dly_q[1] <= side_s2;
			for (int j = 2; j <= DIV_STEPS; j++) begin
				side_dly_q[j] <= side_dly_q[j-1];
			end
		end

		assign sd = side_dly_q[DIV_STEPS];

		always_comb begin
			for (int k = 0; k < 4; k++) begin
				for (int t = 0; t < 2; t++) begin
					if (sd.dz[k][t]) begin
						term[k][t] = '0;
					end else if (sd.neg[k][t]) begin
						term[k][t] = -$signed({2'b0, quo[k][t]});
					end else begin
						term[k][t] = $signed({2'b0, quo[k][t]});
					end
				end
				res[k] = sd.ctx.gate[p][k] ? clamp_unit(term[k][0] + term[k][1]) : '0;
			end
		end

		always_ff @(posedge clk) begin
			ctx_c[p] <= sd.ctx;
			cur_c[p] <= res;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1d   <= 1'b0;
				vld_s2    <= 1'b0;
				vld_dly_q <= '0;
				vld_c[p]  <= 1'b0;
			end else begin
				vld_s1d   <= vld_c[p-1];
				vld_s2    <= vld_s1d;
				vld_dly_q <= {vld_dly_q[DIV_STEPS-2:0], vld_s2};
				vld_c[p]  <= vld_dly_q[DIV_STEPS-1];
			end
		end
	end

	// x on the last knot overrides the recursion
	always_ff @(posedge clk) begin
		if (ctx_c[3].last) begin
			basis_q <= {{BW{1'b0}}, {BW{1'b0}}, {BW{1'b0}}, UNIT_Q30};
		end else begin
			basis_q <= cur_c[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_c[3];
		end
	end

	assign done           = done_q;
	assign basis_i        = basis_q[0];
	assign basis_i_minus1 = basis_q[1];
	assign basis_i_minus2 = basis_q[2];
	assign basis_i_minus3 = basis_q[3];

	a_done_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && mode == MODE_EVAL, LATENCY))
		else $error("result without a matching evaluate item");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (basis_i <= UNIT_Q30 && basis_i_minus1 <= UNIT_Q30 &&
			basis_i_minus2 <= UNIT_Q30 && basis_i_minus3 <= UNIT_Q30))
		else $error("basis value above one");

	a_span_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && mode == MODE_EVAL && span_index == '0, LATENCY) |->
			(basis_i_minus1 == '0 && basis_i_minus2 == '0 && basis_i_minus3 == '0))
		else $error("lane below the first knot not zero");

endmodule

// ----- tb/sv/cbb_checker.sv -----
`timescale 1ns / 100ps
module cbb_checker import cbb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 mode,
	input  logic [KNOT_AW-1:0]   knot_addr,
	input  logic signed [KW-1:0] knot_value,
	input  logic [KNOT_AW-1:0]   span_index,
	input  logic signed [KW-1:0] point_x,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [6:0]           cfg_data,
	input  logic                 done,
	input  logic [BW-1:0]        basis_i,
	input  logic [BW-1:0]        basis_i_minus1,
	input  logic [BW-1:0]        basis_i_minus2,
	input  logic [BW-1:0]        basis_i_minus3,
	output int                   pending,
	output int                   fails
);

	typedef logic [3:0][BW-1:0] basis_set_t;

	longint     knots_model [MAX_KNOTS];
	logic [6:0] count_model;
	basis_set_t basis_q[$];
	string      lane_name [4] = '{"basis_i", "basis_i_minus1", "basis_i_minus2",
		"basis_i_minus3"};

	function automatic longint clamp_q30(input longint v);
		if (v < 0) return 0;
		if (v > (longint'(1) << 30)) return longint'(1) << 30;
		return v;
	endfunction

	function automatic basis_set_t eval_basis(input int span, input longint x);
		longint cur [4];
		longint nxt [4];
		longint dl, dr, prv, lt, rt;
		int n, idx;
		basis_set_t r;
		n = count_model;
		if (n < 2) n = 2;
		if (n > MAX_KNOTS) n = MAX_KNOTS;
		if (x == knots_model[n-1]) begin
			r[0] = UNIT_Q30;
			r[1] = '0;
			r[2] = '0;
			r[3] = '0;
			return r;
		end
		for (int l = 0; l < 4; l++) begin
			idx = span - l;
			cur[l] = 0;
			if (idx >= 0 && idx + 1 < n && knots_model[idx] <= x && x < knots_model[idx+1])
				cur[l] = longint'(1) << 30;
		end
		for (int p = 1; p <= 3; p++) begin
			for (int l = 0; l < 4; l++) begin
				idx = span - l;
				nxt[l] = 0;
				if (idx >= 0 && idx + p + 1 < n) begin
					dl = knots_model[idx+p] - knots_model[idx];
					dr = knots_model[idx+p+1] - knots_model[idx+1];
					prv = (l > 0) ? cur[l-1] : 0;
					lt = 0;
					rt = 0;
					if (dl != 0) lt = ((x - knots_model[idx]) * cur[l]) / dl;
					if (dr != 0) rt = ((knots_model[idx+p+1] - x) * prv) / dr;
					nxt[l] = clamp_q30(lt + rt);
				end
			end
			cur = nxt;
		end
		for (int l = 0; l < 4; l++) r[l] = cur[l][BW-1:0];
		return r;
	endfunction

	assign pending = basis_q.size();

	always @(posedge clk or negedge arst_n) begin
		basis_set_t e, a;
		if (!arst_n) begin
			count_model <= 7'd64;
			fails = 0;
			basis_q.delete();
			for (int k = 0; k < MAX_KNOTS; k++) knots_model[k] = 0;
		end else begin
			if (done) begin
				a = {basis_i_minus3, basis_i_minus2, basis_i_minus1, basis_i};
				if (basis_q.size() == 0) begin
					$error("result with nothing outstanding");
					fails++;
				end else begin
					e = basis_q.pop_front();
					for (int l = 0; l < 4; l++)
						if (e[l] !== a[l]) begin
							$error("%s: expected %0d, got %0d", lane_name[l], e[l], a[l]);
							fails++;
						end
				end
			end
			if (start && !busy) begin
				if (mode == MODE_LOAD)
					knots_model[knot_addr] = longint'(knot_value);
				else
					basis_q.push_back(eval_basis(int'(span_index), longint'(point_x)));
			end
			if (cfg_valid && cfg_ready) count_model <= cfg_data;
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
	import cbb_pkg::*;

	localparam int STALL_LIMIT = 4000;

	logic                 clk, arst_n;
	logic                 start, busy, mode;
	logic [KNOT_AW-1:0]   knot_addr, span_index;
	logic signed [KW-1:0] knot_value, point_x;
	logic                 cfg_valid, cfg_ready;
	logic [6:0]           cfg_data;
	logic                 done;
	logic [BW-1:0]        basis_i, basis_i_minus1, basis_i_minus2, basis_i_minus3;
	int                   pending, fails, quiet_cycles;
	bit                   no_gaps;
	longint               knots_tb [MAX_KNOTS];
	int                   n_eff;

	cubic_bspline_basis_eval uut (.*);

	cbb_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic issue(input logic m, input int addr, input longint kval,
			input int span, input longint x);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		mode       <= m;
		knot_addr  <= addr[KNOT_AW-1:0];
		knot_value <= kval[KW-1:0];
		span_index <= span[KNOT_AW-1:0];
		point_x    <= x[KW-1:0];
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic load_knot(input int addr, input longint v);
		knots_tb[addr] = v;
		issue(MODE_LOAD, addr, v, $urandom_range(0, 63), {$urandom, $urandom});
	endtask

	task automatic eval_at(input int span, input longint x);
		issue(MODE_EVAL, $urandom_range(0, 63), {$urandom, $urandom}, span, x);
	endtask

	// drain the pipeline, then write the knot count
	task automatic set_count(input logic [6:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		n_eff = (v < 2) ? 2 : ((v > MAX_KNOTS) ? MAX_KNOTS : v);
	endtask

	// nondecreasing knots with repeats; wide spacing reaches the extremes
	task automatic load_sorted(input int cnt, input bit wide);
		longint t, stp;
		t = wide ? -64'sd2147483648 : $signed($urandom_range(0, 1 << 22)) - (1 << 21);
		for (int k = 0; k < cnt; k++) begin
			if (k == cnt - 1 && wide) t = 64'sd2147483647;
			load_knot(k, t);
			stp = ($urandom_range(0, 3) == 0) ? 0 :
				(wide ? $urandom_range(1, 1 << 26) : $urandom_range(1, 1 << 18));
			t = t + stp;
			if (t > 64'sd2147483647) t = 64'sd2147483647;
		end
	endtask

	function automatic longint pick_point(input int span);
		longint lo, hi;
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return knots_tb[n_eff-1];
		if (r == 1) return $signed($urandom);
		if (r == 2) return knots_tb[span];
		if (span + 1 >= n_eff) return knots_tb[span] + $urandom_range(0, 1 << 16);
		lo = knots_tb[span];
		hi = knots_tb[span+1];
		if (hi <= lo) return lo;
		return lo + ({$urandom, $urandom} & 64'h7fffffffffffffff) % (hi - lo);
	endfunction

	task automatic random_phase(input int evals, input int loads_in);
		int span;
		for (int j = 0; j < evals; j++) begin
			if (j % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 20) < loads_in)
				load_knot($urandom_range(0, n_eff - 1),
					knots_tb[$urandom_range(0, n_eff - 1)]);
			span = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) :
				$urandom_range(0, n_eff - 1);
			eval_at(span, pick_point(span));
		end
	endtask

	initial begin
		logic [6:0] counts [7];
		start = 0; mode = 0; knot_addr = 0; knot_value = 0;
		span_index = 0; point_x = 0; cfg_valid = 0; cfg_data = 0;
		quiet_cycles = 0; no_gaps = 0; n_eff = MAX_KNOTS;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: full store with extreme end knots, then corner points
		set_count(7'd64);
		load_sorted(MAX_KNOTS, 1'b1);
		eval_at(5, knots_tb[63]);
		eval_at(63, knots_tb[63]);
		eval_at(0, -64'sd2147483648);
		eval_at(62, 64'sd2147483646);
		eval_at(0, knots_tb[0]);
		eval_at(1, knots_tb[1]);
		eval_at(2, knots_tb[2]);
		eval_at(63, knots_tb[63] - 1);
		eval_at(30, knots_tb[30]);
		eval_at(31, knots_tb[20]);
		eval_at(10, knots_tb[40]);
		load_knot(63, 64'sd2147483647);
		eval_at(4, 64'sd2147483647);

		counts = '{7'd2, 7'd127, 7'd0, 7'd1, 7'd9, 7'd64, 7'd65};
		foreach (counts[c]) begin
			set_count(($urandom_range(0, 1) == 0) ? counts[c] : counts[c]);
			load_sorted(n_eff, c == 5);
			random_phase(c == 5 ? 50 : 10, 2);
		end
		set_count(7'($urandom_range(3, 63)));
		load_sorted(n_eff, 1'b0);
		random_phase(40, 4);

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/cbb_pkg.sv
hdl/cbb_div.sv
hdl/cubic_bspline_basis_eval.sv
tb/sv/cbb_checker.sv
tb/sv/tb_top.sv
